FILE: hdl/tpsd_pkg.sv
// ----------------------------------------------------------------------------
// tpsd_pkg
// Shared types and constants of the TGA pixel stream decoder.
// ----------------------------------------------------------------------------
package tpsd_pkg;

  // Widths of the configuration port and the pixel counters
  localparam int unsigned CFG_IDX_W  = 2;
  localparam int unsigned CFG_DATA_W = 25;
  localparam int unsigned COUNT_W    = 25;

  // Register indexes
  localparam logic [CFG_IDX_W-1:0] REG_PIXEL_FORMAT     = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_RUN_LENGTH_CODED = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_PIXEL_TOTAL      = 2'd2;

  // Pixel format codes (code three decodes like BGRA)
  localparam logic [1:0] FMT_GRAY = 2'd0;
  localparam logic [1:0] FMT_BGR  = 2'd1;
  localparam logic [1:0] FMT_BGRA = 2'd2;

  // Packet header layout
  localparam int unsigned  HDR_RUN_BIT = 7;
  localparam logic [7:0]   MAX_RUN     = 8'd128;

  // Configuration as seen by the parser
  typedef struct packed {
    logic [1:0]         pixel_format;
    logic               run_length_coded;
    logic [COUNT_W-1:0] pixel_total;
  } tpsd_cfg_t;

  // One pixel token
  typedef struct packed {
    logic [7:0] gray_or_red;
    logic [7:0] green;
    logic [7:0] blue;
    logic [7:0] alpha;
    logic [7:0] repeat_count;
    logic       last_pixel;
  } tpsd_pix_t;

endpackage

FILE: hdl/tpsd_in_if.sv
// ----------------------------------------------------------------------------
// tpsd_in_if
// Byte channel into the decoder.
// ----------------------------------------------------------------------------
interface tpsd_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] in_byte;
  logic       image_start;

  modport source (output valid, output in_byte, output image_start, input ready);
  modport sink   (input valid, input in_byte, input image_start, output ready);
endinterface

FILE: hdl/tpsd_out_if.sv
// ----------------------------------------------------------------------------
// tpsd_out_if
// Pixel token channel out of the decoder.
// ----------------------------------------------------------------------------
interface tpsd_out_if;
  logic       valid;
  logic       ready;
  logic [7:0] gray_or_red;
  logic [7:0] green;
  logic [7:0] blue;
  logic [7:0] alpha;
  logic [7:0] repeat_count;
  logic       last_pixel;

  modport source (output valid, output gray_or_red, output green, output blue,
                  output alpha, output repeat_count, output last_pixel, input ready);
  modport sink   (input valid, input gray_or_red, input green, input blue,
                  input alpha, input repeat_count, input last_pixel, output ready);
endinterface

FILE: hdl/tpsd_cfg_if.sv
// ----------------------------------------------------------------------------
// tpsd_cfg_if
// Register write channel of the decoder.
// ----------------------------------------------------------------------------
interface tpsd_cfg_if;
  import tpsd_pkg::*;
  logic                  valid;
  logic                  ready;
  logic [CFG_IDX_W-1:0]  index;
  logic [CFG_DATA_W-1:0] data;

  modport source (output valid, output index, output data, input ready);
  modport sink   (input valid, input index, input data, output ready);
endinterface

FILE: hdl/tpsd_cfg_regs.sv
// ----------------------------------------------------------------------------
// tpsd_cfg_regs
// Configuration registers, written one beat at a time.
// ----------------------------------------------------------------------------
module tpsd_cfg_regs
  import tpsd_pkg::*;
(
  input  logic       clk,
  input  logic       rst_n,
  tpsd_cfg_if.sink   cfg_if,
  output tpsd_cfg_t  cfg
);

  logic [1:0]         pixel_format_r;
  logic               run_length_coded_r;
  logic [COUNT_W-1:0] pixel_total_r;
  logic               wr_en;

  // Writes are always taken
  assign cfg_if.ready = 1'b1;
  assign wr_en        = cfg_if.valid;

  // Register file; indexes past the list are dropped
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pixel_format_r     <= FMT_BGR;
      run_length_coded_r <= 1'b0;
      pixel_total_r      <= COUNT_W'(1);
    end else if (wr_en) begin
      unique case (cfg_if.index)
        REG_PIXEL_FORMAT:     pixel_format_r     <= cfg_if.data[1:0];
        REG_RUN_LENGTH_CODED: run_length_coded_r <= cfg_if.data[0];
        REG_PIXEL_TOTAL:      pixel_total_r      <= cfg_if.data[COUNT_W-1:0];
        default: ;
      endcase
    end
  end

  assign cfg.pixel_format     = pixel_format_r;
  assign cfg.run_length_coded = run_length_coded_r;
  assign cfg.pixel_total      = pixel_total_r;

endmodule

FILE: hdl/tpsd_parser.sv
// ----------------------------------------------------------------------------
// tpsd_parser
// Parse state and single-pass decode of one byte into at most one token.
// ----------------------------------------------------------------------------
module tpsd_parser
  import tpsd_pkg::*;
(
  input  logic      clk,
  input  logic      rst_n,
  input  tpsd_cfg_t cfg,
  input  logic      step,
  input  logic [7:0] in_byte,
  input  logic      image_start,
  output logic      res_valid,
  output tpsd_pix_t res
);

  logic               expect_header_r, expect_header_nxt;
  logic               packet_is_run_r, packet_is_run_nxt;
  logic [7:0]         pkt_left_r, pkt_left_nxt;
  logic [1:0]         byte_in_pixel_r, byte_in_pixel_nxt;
  logic [23:0]        colour_r, colour_nxt;
  logic [COUNT_W-1:0] pixels_done_r, pixels_done_nxt;

  // State after an image start, before the byte is used
  logic               eff_expect, eff_is_run;
  logic [7:0]         eff_left;
  logic [1:0]         eff_bip;
  logic [23:0]        eff_colour;
  logic [COUNT_W-1:0] eff_done;

  logic [2:0]         bpp;
  logic [2:0]         bip_inc;
  logic [7:0]         rep, left_dec;
  logic [COUNT_W-1:0] remaining, rep_ext;

  always_comb begin
    // Image start clears counters and parse phase
    if (image_start) begin
      eff_expect = 1'b1;
      eff_is_run = 1'b0;
      eff_left   = '0;
      eff_bip    = '0;
      eff_colour = '0;
      eff_done   = '0;
    end else begin
      eff_expect = expect_header_r;
      eff_is_run = packet_is_run_r;
      eff_left   = pkt_left_r;
      eff_bip    = byte_in_pixel_r;
      eff_colour = colour_r;
      eff_done   = pixels_done_r;
    end

    unique case (cfg.pixel_format)
      FMT_GRAY: bpp = 3'd1;
      FMT_BGR:  bpp = 3'd3;
      default:  bpp = 3'd4;
    endcase

    bip_inc   = {1'b0, eff_bip} + 3'd1;
    remaining = cfg.pixel_total - eff_done;
    left_dec  = (eff_left != 8'd0) ? (eff_left - 8'd1) : 8'd0;

    expect_header_nxt = eff_expect;
    packet_is_run_nxt = eff_is_run;
    pkt_left_nxt      = eff_left;
    byte_in_pixel_nxt = eff_bip;
    colour_nxt        = eff_colour;
    pixels_done_nxt   = eff_done;
    res_valid         = 1'b0;
    res               = '0;
    rep               = 8'd1;
    rep_ext           = '0;

    priority if (eff_done >= cfg.pixel_total) begin
      // Image complete: byte ignored
    end else if (cfg.run_length_coded && eff_expect) begin
      // Packet header
      packet_is_run_nxt = in_byte[HDR_RUN_BIT];
      pkt_left_nxt      = {1'b0, in_byte[HDR_RUN_BIT-1:0]} + 8'd1;
      expect_header_nxt = 1'b0;
      byte_in_pixel_nxt = '0;
      colour_nxt        = '0;
    end else if (bip_inc < bpp) begin
      // Collect a color byte
      unique case (eff_bip)
        2'd0:    colour_nxt = eff_colour | {16'd0, in_byte};
        2'd1:    colour_nxt = eff_colour | {8'd0, in_byte, 8'd0};
        2'd2:    colour_nxt = eff_colour | {in_byte, 16'd0};
        default: colour_nxt = eff_colour;
      endcase
      byte_in_pixel_nxt = bip_inc[1:0];
    end else begin
      // Final byte of the pixel: swap channels and emit
      res_valid = 1'b1;
      unique case (bpp)
        3'd1: begin
          res.gray_or_red = in_byte;
        end
        3'd3: begin
          res.gray_or_red = in_byte;
          res.green       = eff_colour[15:8];
          res.blue        = eff_colour[7:0];
        end
        default: begin
          res.gray_or_red = eff_colour[23:16];
          res.green       = eff_colour[15:8];
          res.blue        = eff_colour[7:0];
          res.alpha       = in_byte;
        end
      endcase
      byte_in_pixel_nxt = '0;
      colour_nxt        = '0;

      // Packet bookkeeping
      if (cfg.run_length_coded) begin
        if (eff_is_run) begin
          priority if (eff_left == 8'd0) rep = 8'd1;
          else if (eff_left > MAX_RUN)   rep = MAX_RUN;
          else                           rep = eff_left;
          pkt_left_nxt      = '0;
          expect_header_nxt = 1'b1;
        end else begin
          pkt_left_nxt = left_dec;
          if (left_dec == 8'd0) expect_header_nxt = 1'b1;
        end
      end

      // Clip to the pixels still missing
      rep_ext = {{(COUNT_W-8){1'b0}}, rep};
      if (remaining < rep_ext) rep_ext = remaining;
      pixels_done_nxt  = eff_done + rep_ext;
      res.repeat_count = rep_ext[7:0];
      res.last_pixel   = (pixels_done_nxt >= cfg.pixel_total);
    end
  end

  // Parse state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      expect_header_r <= 1'b1;
      packet_is_run_r <= 1'b0;
      pkt_left_r      <= '0;
      byte_in_pixel_r <= '0;
      colour_r        <= '0;
      pixels_done_r   <= '0;
    end else if (step) begin
      expect_header_r <= expect_header_nxt;
      packet_is_run_r <= packet_is_run_nxt;
      pkt_left_r      <= pkt_left_nxt;
      byte_in_pixel_r <= byte_in_pixel_nxt;
      colour_r        <= colour_nxt;
      pixels_done_r   <= pixels_done_nxt;
    end
  end

  // Checks
  a_rep_max: assert property (@(posedge clk) disable iff (!rst_n)
    res_valid |-> (res.repeat_count <= MAX_RUN))
    else $error("token repeat count above maximum run");
  a_pkt_left: assert property (@(posedge clk) disable iff (!rst_n)
    pkt_left_r <= MAX_RUN)
    else $error("packet count above maximum run");
  a_rep_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
    res_valid |-> (res.repeat_count != 8'd0))
    else $error("token with zero repeat count");

endmodule

FILE: hdl/tga_pixel_stream_decoder.sv
// ----------------------------------------------------------------------------
// tga_pixel_stream_decoder
// TGA pixel-data decoder: raw or run-length bytes in, gray, RGB or RGBA tokens out.
// ----------------------------------------------------------------------------
// A token is taken into the input register with its final byte, then into
//   the result register once that register is free or drains.
// Throughput: one byte per cycle while the output is not stalled, set by the single-pass parse stage.
// Reset (synchronous, rst_n low): pipeline empty, parse state cleared,
//   registers return to BGR, raw data, one pixel.
module tga_pixel_stream_decoder
  import tpsd_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  tpsd_in_if.sink     in_if,
  tpsd_out_if.source  out_if,
  tpsd_cfg_if.sink    cfg_if
);

  tpsd_cfg_t  cfg;
  logic       in_valid_r;
  logic [7:0] in_byte_r;
  logic       in_start_r;
  logic       advance;
  logic       res_valid;
  tpsd_pix_t  res;
  logic       out_valid_r;
  tpsd_pix_t  out_r;

  tpsd_cfg_regs u_cfg (
    .clk    (clk),
    .rst_n  (rst_n),
    .cfg_if (cfg_if),
    .cfg    (cfg)
  );

  // Stage handshake: parse moves when the result register is free or drains
  assign advance     = in_valid_r && (!out_valid_r || out_if.ready);
  assign in_if.ready = !in_valid_r || advance;

  // Input register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_valid_r <= 1'b0;
    end else if (in_if.ready) begin
      in_valid_r <= in_if.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_if.ready && in_if.valid) begin
      in_byte_r  <= in_if.in_byte;
      in_start_r <= in_if.image_start;
    end
  end

  tpsd_parser u_parser (
    .clk         (clk),
    .rst_n       (rst_n),
    .cfg         (cfg),
    .step        (advance),
    .in_byte     (in_byte_r),
    .image_start (in_start_r),
    .res_valid   (res_valid),
    .res         (res)
  );

  // Result register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (advance) begin
      out_valid_r <= res_valid;
    end else if (out_if.ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance && res_valid) begin
      out_r <= res;
    end
  end

  assign out_if.valid        = out_valid_r;
  assign out_if.gray_or_red  = out_r.gray_or_red;
  assign out_if.green        = out_r.green;
  assign out_if.blue         = out_r.blue;
  assign out_if.alpha        = out_r.alpha;
  assign out_if.repeat_count = out_r.repeat_count;
  assign out_if.last_pixel   = out_r.last_pixel;

  // Checks
  a_stall_full: assert property (@(posedge clk) disable iff (!rst_n)
    !in_if.ready |-> (in_valid_r && out_valid_r))
    else $error("input stalled with a free stage");
  a_token_lands: assert property (@(posedge clk) disable iff (!rst_n)
    (advance && res_valid) |=> out_valid_r)
    else $error("decoded token not registered");
  a_no_drop: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && !out_if.ready) |-> !advance)
    else $error("parse advanced over a waiting token");

endmodule
